### rtl/core/msc_pkg.sv
// Package for the minimum square sum counter.
// Shared widths, constants and the command/status words between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

	localparam int TARGET_W = 12;
	localparam int COUNT_W  = 3;

	// Running minimum starts at all ones; j = 1 always replaces it
	localparam logic [COUNT_W-1:0] COUNT_SENTINEL = '1;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // latch the incoming target word
		logic init;      // write entry 0, set up the first entry to build
		logic issue;     // read entry i - j*j and step j
		logic write;     // store the running minimum into entry i
		logic next;      // move on to entry i + 1
		logic load_out;  // move the answer into the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic sq_le_i;       // j*j <= i, another read is due
		logic last;          // entry being built is the target
		logic zero;          // target is zero
		logic out_free;      // output register can take a word this cycle
		logic fold_pending;  // a read word is still being folded into the minimum
	} status_t;

endpackage

`default_nettype wire

### rtl/core/msc_ctrl.sv
// Controller state machine for the minimum square sum counter.
// Sequences table init, reads, writes and result hand-off. Depends on msc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire msc_pkg::status_t status,
	output msc_pkg::cmd_t         cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INIT   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_WRITE  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Take a new word only between items
	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = status.zero ? ST_FINISH : ST_READ;
			end
			ST_READ: begin
				if (status.sq_le_i) begin
					cmd.issue = 1'b1;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				if (status.last) begin
					state_d = ST_FINISH;
				end else begin
					cmd.next = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/msc_datapath.sv
// Datapath for the minimum square sum counter: table memory, loop counters,
// running minimum and output register. Depends on msc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msc_datapath #(
	parameter int MAX_TARGET = 4095
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [msc_pkg::TARGET_W-1:0]  target,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [msc_pkg::COUNT_W-1:0]   square_count,
	input  wire msc_pkg::cmd_t                 cmd,
	output msc_pkg::status_t                   status
);

	localparam int TMAX  = (1 << msc_pkg::TARGET_W) - 1;
	localparam int LIMIT = (MAX_TARGET < TMAX) ? MAX_TARGET : TMAX;
	localparam int DEPTH = LIMIT + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = AW + 2;
	localparam int JW    = (AW + 1) / 2 + 1;
	localparam int CW    = msc_pkg::COUNT_W;

	logic [CW-1:0] mem [DEPTH];

	logic [AW-1:0] t_q;
	logic [AW-1:0] i_q;
	logic [JW-1:0] j_q;
	logic [SW-1:0] sq_q;
	logic [CW-1:0] min_q;
	logic [CW-1:0] rd_data_s1;
	logic          rd_valid_s1;
	logic [CW-1:0] out_q;
	logic          out_valid_q;

	logic [AW-1:0] rd_addr;
	logic [CW-1:0] cand;
	logic [AW-1:0] t_sat;

	// Saturate the target to the table size
	assign t_sat = (32'(target) > LIMIT) ? AW'(LIMIT) : target[AW-1:0];

	assign rd_addr = i_q - sq_q[AW-1:0];
	assign cand    = rd_data_s1 + CW'(1);

	assign status.sq_le_i      = (sq_q <= SW'(i_q));
	assign status.last         = (i_q == t_q);
	assign status.zero         = (t_q == '0);
	assign status.out_free     = !out_valid_q || !out_stall;
	assign status.fold_pending = rd_valid_s1;

	assign out_valid    = out_valid_q;
	assign square_count = out_q;

	// Table memory, one read or one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			mem[0] <= '0;
		end else if (cmd.write) begin
			mem[i_q] <= min_q;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Loop counters and running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			sq_q        <= '0;
			min_q       <= msc_pkg::COUNT_SENTINEL;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cmd.capture) begin
				t_q <= t_sat;
			end
			if (cmd.init || cmd.next) begin
				i_q   <= cmd.init ? AW'(1) : i_q + AW'(1);
				j_q   <= JW'(1);
				sq_q  <= SW'(1);
				min_q <= (cmd.init && status.zero) ? '0 : msc_pkg::COUNT_SENTINEL;
			end else begin
				if (cmd.issue) begin
					j_q  <= j_q + JW'(1);
					sq_q <= sq_q + SW'({j_q, 1'b1});
				end
				// Fold the word read last cycle
				if (rd_valid_s1 && (cand < min_q)) begin
					min_q <= cand;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= min_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### rtl/core/min_square_sum_count.sv
// Minimum square sum counter: fewest perfect squares summing to a target word.
// Run time for target t (after saturation) is set by the one table memory read port:
// each entry i = 1..t is built from one read per j with j*j <= i.
// One item at a time; the next word is taken once the result sits in the output register.
// Reset (arst_n low) clears control state; table contents stay undefined and are
// rebuilt by every item, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module min_square_sum_count #(
	parameter int MAX_TARGET = 4095
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [msc_pkg::TARGET_W-1:0]  target,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [msc_pkg::COUNT_W-1:0]   square_count
);

	msc_pkg::cmd_t    cmd;
	msc_pkg::status_t status;

	msc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	msc_datapath #(
		.MAX_TARGET (MAX_TARGET)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.target       (target),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.square_count (square_count),
		.cmd          (cmd),
		.status       (status)
	);

	// An accepted word starts the table build on the next cycle
	a_accept_init: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> cmd.init)
		else $error("accepted word did not start table init");

	// Entry write only after the last read word was folded in
	a_write_folded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !status.fold_pending)
		else $error("table write while a read word was still pending");

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.load_out)
		else $error("output register overwritten while stalled");

	// Four squares always suffice
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (square_count <= msc_pkg::COUNT_W'(4)))
		else $error("square count above four");

endmodule

`default_nettype wire

### sim/min_square_sum_count_tb.sv
// Testbench for min_square_sum_count: sends target words and checks each returned count
// against a typed row count or a minimum square count table built at time zero.
// Depends on msc_pkg and the min_square_sum_count RTL.
`timescale 1ns / 1ps

module min_square_sum_count_tb;

	localparam int MAX_T        = 4095;
	localparam int LIMIT_CYCLES = 12_000_000;
	localparam int N_ROWS       = 24;
	localparam int N_RANDOM     = 76;
	localparam int MAX_BIG      = 3;
	localparam int TAIL_CYCLES  = 64;
	localparam int IDLE_PCT     = 32;

	// Row kinds in the directed table
	localparam bit TYPED     = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef struct packed {
		logic [msc_pkg::TARGET_W-1:0] tgt;
		logic                         typed;
		logic [msc_pkg::COUNT_W-1:0]  count;
	} row_t;

	// Directed words: zero, small values, squares, four-square values, the top of the range
	row_t dir_rows [N_ROWS] = '{
		'{12'd0,    TYPED,     3'd0},
		'{12'd1,    TYPED,     3'd1},
		'{12'd2,    PREDICTED, 3'd0},
		'{12'd3,    PREDICTED, 3'd0},
		'{12'd4,    TYPED,     3'd1},
		'{12'd5,    PREDICTED, 3'd0},
		'{12'd7,    PREDICTED, 3'd0},
		'{12'd8,    PREDICTED, 3'd0},
		'{12'd12,   PREDICTED, 3'd0},
		'{12'd13,   PREDICTED, 3'd0},
		'{12'd15,   PREDICTED, 3'd0},
		'{12'd16,   TYPED,     3'd1},
		'{12'd23,   PREDICTED, 3'd0},
		'{12'd28,   PREDICTED, 3'd0},
		'{12'd31,   PREDICTED, 3'd0},
		'{12'd48,   PREDICTED, 3'd0},
		'{12'd63,   PREDICTED, 3'd0},
		'{12'd64,   TYPED,     3'd1},
		'{12'd100,  TYPED,     3'd1},
		'{12'd127,  PREDICTED, 3'd0},
		'{12'd128,  PREDICTED, 3'd0},
		'{12'd255,  PREDICTED, 3'd0},
		'{12'd1023, PREDICTED, 3'd0},
		'{12'd4095, PREDICTED, 3'd0}
	};

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [msc_pkg::TARGET_W-1:0] target;
	logic                         out_valid;
	logic                         out_stall;
	logic [msc_pkg::COUNT_W-1:0]  square_count;

	// Predicted minimum counts for every target word, and counts still owed by the block
	logic [msc_pkg::COUNT_W-1:0] min_count [0:MAX_T];
	logic [msc_pkg::COUNT_W-1:0] pending_counts [$];

	int  mismatches  = 0;
	int  checked     = 0;
	int  sent        = 0;
	int  big_sent    = 0;
	int  cycle_count = 0;
	bit  quiet       = 1'b0;

	min_square_sum_count #(
		.MAX_TARGET(MAX_T)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.target      (target),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.square_count(square_count)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic log_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Bottom-up table: entry i is one plus the smallest entry i - j*j over j*j <= i
	task automatic build_min_counts();
		logic [msc_pkg::COUNT_W-1:0] best;
		logic [msc_pkg::COUNT_W-1:0] cand;
		int i;
		int j;
		min_count[0] = '0;
		for (i = 1; i <= MAX_T; i++) begin
			best = msc_pkg::COUNT_SENTINEL;
			for (j = 1; j * j <= i; j++) begin
				cand = min_count[i - j * j] + 1'b1;
				if (cand < best)
					best = cand;
			end
			min_count[i] = best;
		end
	endtask

	// Targets above the top entry saturate to it
	function automatic logic [msc_pkg::COUNT_W-1:0] count_for(
		input logic [msc_pkg::TARGET_W-1:0] t);
		int idx;
		idx = (int'(t) > MAX_T) ? MAX_T : int'(t);
		return min_count[idx];
	endfunction

	// Offer one word, after random idle cycles unless quiet; the payload holds until taken
	task automatic send_target(input logic [msc_pkg::TARGET_W-1:0] t,
		input logic [msc_pkg::COUNT_W-1:0] want);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			target   <= msc_pkg::TARGET_W'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target   <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_counts.push_back(want);
		sent++;
	endtask

	// Hold the sender off until the block has handed back every count
	task automatic wait_for_counts();
		in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stall, and check of every word taken
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_counts.size() == 0) begin
				log_mismatch($sformatf("unexpected count word %0d", square_count));
			end else begin
				if (square_count !== pending_counts[0])
					log_mismatch($sformatf("square_count %0d, expected %0d",
						square_count, pending_counts[0]));
				void'(pending_counts.pop_front());
				checked++;
			end
		end
		out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d counts still owed",
				cycle_count, pending_counts.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus: directed table, then random words mostly small with a few large ones
	initial begin
		logic [msc_pkg::TARGET_W-1:0] t;
		logic [msc_pkg::COUNT_W-1:0]  want;
		int k;
		int r;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		target    = '0;
		out_stall = 1'b0;
		build_min_counts();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_ROWS; k++) begin
			t    = dir_rows[k].tgt;
			want = (dir_rows[k].typed == TYPED) ? dir_rows[k].count : count_for(t);
			send_target(t, want);
		end
		wait_for_counts();

		for (k = 0; k < N_RANDOM; k++) begin
			quiet = (k >= 30 && k < 55);
			if (k == 60)
				wait_for_counts();
			r = $urandom_range(0, 99);
			if (r < 3 && big_sent < MAX_BIG) begin
				t = msc_pkg::TARGET_W'($urandom_range(1024, MAX_T));
				big_sent++;
			end else if (r < 15) begin
				t = msc_pkg::TARGET_W'($urandom_range(128, 1023));
			end else begin
				t = msc_pkg::TARGET_W'($urandom_range(0, 127));
			end
			send_target(t, count_for(t));
		end
		quiet = 1'b0;

		wait_for_counts();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d target words: %0d from the table, %0d random, %0d of them 1024+.",
			sent, N_ROWS, N_RANDOM, big_sent);
		$display("Checked %0d count words in %0d cycles, %0d mismatches.",
			checked, cycle_count, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/core/msc_pkg.sv
rtl/core/msc_ctrl.sv
rtl/core/msc_datapath.sv
rtl/core/min_square_sum_count.sv
sim/min_square_sum_count_tb.sv
